FILE: rtl/dmftlb_pkg.sv
// shared types and constants for the direct-mapped fetch translation cache
package dmftlb_pkg;

    localparam int ADDR_W        = 64;
    localparam int OFFSET_W      = 12;
    localparam int PAGE_W        = ADDR_W - OFFSET_W;
    localparam int CMD_W         = 2;
    localparam int IDX_STEP_BITS = 4;
    localparam int IDX_STEPS     = PAGE_W / IDX_STEP_BITS;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_COMPARE
    } t_state;

endpackage

FILE: rtl/dmftlb_ram.sv
// single-port synchronous ram with registered read data
module dmftlb_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 52
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dmftlb_index.sv
// page number to entry index: bit select for power-of-two sizes, serial remainder otherwise
module dmftlb_index #(
    parameter int ENTRIES = 8192
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [dmftlb_pkg::PAGE_W-1:0]       i_vpage,
    output logic                                o_done,
    output logic [$clog2(ENTRIES)-1:0]          o_index
);

    import dmftlb_pkg::*;

    localparam int  IDX_W   = $clog2(ENTRIES);
    localparam bit  IS_POW2 = ((ENTRIES & (ENTRIES - 1)) == 0);

    generate
        if (IS_POW2) begin : g_mask
            logic             r_done;
            logic [IDX_W-1:0] r_index;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_index <= i_vpage[IDX_W-1:0];
                end
            end

            assign o_done  = r_done;
            assign o_index = r_index;
        end else begin : g_serial
            localparam int REM_W = IDX_W + 1;
            localparam int CNT_W = $clog2(IDX_STEPS);
            localparam logic [REM_W-1:0] ENTRY_CNT = REM_W'(ENTRIES);
            localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(IDX_STEPS - 1);

            logic              r_busy;
            logic              r_done;
            logic [CNT_W-1:0]  r_cnt;
            logic [PAGE_W-1:0] r_shift;
            logic [REM_W-1:0]  r_rem;
            logic [REM_W-1:0]  n_rem;

            // one nibble of the page number per cycle, msb first
            always_comb begin
                n_rem = r_rem;
                for (int b = 0; b < IDX_STEP_BITS; b++) begin
                    n_rem = {n_rem[REM_W-2:0], r_shift[PAGE_W-1-b]};
                    if (n_rem >= ENTRY_CNT) begin
                        n_rem = n_rem - ENTRY_CNT;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                    end else if (r_busy) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == LAST_STEP) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_shift <= i_vpage;
                    r_rem   <= '0;
                end else if (r_busy) begin
                    r_shift <= {r_shift[PAGE_W-IDX_STEP_BITS-1:0], {IDX_STEP_BITS{1'b0}}};
                    r_rem   <= n_rem;
                end
            end

            assign o_done  = r_done;
            assign o_index = r_rem[IDX_W-1:0];
        end
    endgenerate

endmodule

FILE: rtl/direct_mapped_fetch_tlb_unit.sv
// direct-mapped instruction-fetch translation cache, top level
//
// channel   direction  handshake                      payload
// request   in         start high while busy low      i_command, i_virtual_address,
//                                                     i_fill_address, i_fill_faulted,
//                                                     i_kernel_mode
// result    out        o_valid high for one cycle     o_hit, o_physical_address,
//                                                     o_walk_needed, o_walk_kernel_fetch
//
// every request gives one result. when ENTRIES is a power of two the entry index is a
// registered bit select, and a fill, flush or ignored command passes the index register
// and the result register, while a lookup passes the index register, the tag and page ram
// read and the result register. otherwise the index comes from a serial remainder unit,
// 4 page bits per cycle, that runs over the whole page number. a fill, lookup or ignored
// command drops busy in the cycle its strobe shows, so a new request may go in beside it.
// a flush strobes its result after the index step, then sweeps every tag ram entry, one
// entry a cycle, busy held high. after reset the same sweep runs before the first request.
// results cannot be stalled: the receiver takes o_valid in the cycle it shows.
module direct_mapped_fetch_tlb_unit #(
    parameter int ENTRIES = 8192
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [dmftlb_pkg::CMD_W-1:0]         i_command,
    input  logic [dmftlb_pkg::ADDR_W-1:0]        i_virtual_address,
    input  logic [dmftlb_pkg::ADDR_W-1:0]        i_fill_address,
    input  logic                                 i_fill_faulted,
    input  logic                                 i_kernel_mode,
    output logic                                 o_valid,
    output logic                                 o_hit,
    output logic [dmftlb_pkg::ADDR_W-1:0]        o_physical_address,
    output logic                                 o_walk_needed,
    output logic                                 o_walk_kernel_fetch
);

    import dmftlb_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // control state
    t_state r_state;
    t_state n_state;
    logic [IDX_W-1:0] r_clr_idx;

    // latched request
    t_cmd                r_cmd;
    logic [ADDR_W-1:0]   r_va;
    logic [PAGE_W-1:0]   r_fill_page;
    logic                r_faulted;
    logic                r_kernel;

    // result registers
    logic                r_out_valid;
    logic                r_out_hit;
    logic [ADDR_W-1:0]   r_out_pa;
    logic                r_out_walk;
    logic                r_out_walk_k;
    logic                n_out_valid;
    logic                n_out_hit;
    logic [ADDR_W-1:0]   n_out_pa;
    logic                n_out_walk;
    logic                n_out_walk_k;

    // ram side
    logic                tag_we;
    logic                page_we;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_addr;
    logic [PAGE_W-1:0]   tag_wdata;
    logic [PAGE_W-1:0]   tag_rdata;
    logic [PAGE_W-1:0]   page_rdata;

    logic                accept;
    logic                idx_done;
    logic [IDX_W-1:0]    idx;
    logic [PAGE_W-1:0]   req_vpage;
    logic                tag_match;

    assign accept    = start && (r_state == ST_IDLE);
    assign busy      = (r_state != ST_IDLE);
    assign req_vpage = r_va[ADDR_W-1:OFFSET_W];
    // page zero is never valid: its tag is the invalid mark
    assign tag_match = (req_vpage != '0) && (tag_rdata == req_vpage);

    dmftlb_index #(
        .ENTRIES (ENTRIES)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_vpage (i_virtual_address[ADDR_W-1:OFFSET_W]),
        .o_done  (idx_done),
        .o_index (idx)
    );

    dmftlb_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (PAGE_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (tag_wdata),
        .o_rdata (tag_rdata)
    );

    dmftlb_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (PAGE_W)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (page_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_fill_page),
        .o_rdata (page_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_INDEX;
                end
            end
            ST_INDEX: begin
                if (idx_done) begin
                    case (r_cmd)
                        CMD_LOOKUP: n_state = ST_COMPARE;
                        CMD_FLUSH:  n_state = ST_CLEAR;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_COMPARE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // ram controls and result values
    always_comb begin
        tag_we       = 1'b0;
        page_we      = 1'b0;
        ram_re       = 1'b0;
        ram_addr     = idx;
        tag_wdata    = req_vpage;
        n_out_valid  = 1'b0;
        n_out_hit    = 1'b0;
        n_out_pa     = '0;
        n_out_walk   = 1'b0;
        n_out_walk_k = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                // sweep: zero tag marks the entry invalid
                tag_we    = 1'b1;
                ram_addr  = r_clr_idx;
                tag_wdata = '0;
            end
            ST_INDEX: begin
                if (idx_done) begin
                    case (r_cmd)
                        CMD_LOOKUP: begin
                            ram_re = 1'b1;
                        end
                        CMD_FILL: begin
                            tag_we      = !r_faulted;
                            page_we     = !r_faulted;
                            n_out_valid = 1'b1;
                        end
                        default: begin
                            // flush and unused code answer with an all-zero result
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_COMPARE: begin
                n_out_valid = 1'b1;
                if (tag_match) begin
                    n_out_hit = 1'b1;
                    n_out_pa  = {page_rdata, r_va[OFFSET_W-1:0]};
                end else begin
                    n_out_walk   = 1'b1;
                    n_out_walk_k = r_kernel;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= (r_clr_idx == LAST_IDX) ? '0 : r_clr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= t_cmd'(i_command);
            r_va        <= i_virtual_address;
            r_fill_page <= i_fill_address[ADDR_W-1:OFFSET_W];
            r_faulted   <= i_fill_faulted;
            r_kernel    <= i_kernel_mode;
        end
        r_out_hit    <= n_out_hit;
        r_out_pa     <= n_out_pa;
        r_out_walk   <= n_out_walk;
        r_out_walk_k <= n_out_walk_k;
    end

    assign o_valid             = r_out_valid;
    assign o_hit               = r_out_hit;
    assign o_physical_address  = r_out_pa;
    assign o_walk_needed       = r_out_walk;
    assign o_walk_kernel_fetch = r_out_walk_k;

endmodule
